/* src/pmc_pkg.sv */
package pmc_pkg;

    localparam int PAGE_W = 32;

    localparam logic [3:0] ORDER_SMALL = 4'd0;
    localparam logic [3:0] BIG_ORDER   = 4'd9;

    localparam int SLOT_COUNT = 2;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_SUPPLY = 2'd2;
    localparam logic [1:0] OP_DRAIN  = 2'd3;

    localparam logic [2:0] KIND_GRANT     = 3'd0;
    localparam logic [2:0] KIND_FAIL      = 3'd1;
    localparam logic [2:0] KIND_UNMANAGED = 3'd2;
    localparam logic [2:0] KIND_FREED     = 3'd3;
    localparam logic [2:0] KIND_RETURN    = 3'd4;
    localparam logic [2:0] KIND_REFILL    = 3'd5;
    localparam logic [2:0] KIND_EMPTY     = 3'd6;
    localparam logic [2:0] KIND_STRAY     = 3'd7;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        cpu;
        logic [3:0]        size_class;
        logic [PAGE_W-1:0] page;
        logic              supply_ok;
    } req_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [PAGE_W-1:0] page_out;
        logic [3:0]        order_out;
        logic [1:0]        cpu_out;
        logic [4:0]        amount;
        logic              last;
    } rsp_t;

    typedef enum logic [1:0] {
        PS_ZERO,
        PS_IN,
        PS_RAM
    } page_sel_t;

    typedef enum logic [1:0] {
        AS_ZERO,
        AS_FILL,
        AS_FILL_INC,
        AS_WANT
    } amount_sel_t;

    typedef struct packed {
        logic        accept;
        logic        pop;
        logic        push;
        logic        set_pending;
        logic        clr_pending;
        logic        emit;
        logic [2:0]  kind;
        page_sel_t   psel;
        amount_sel_t asel;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       unmanaged;
        logic       pending;
        logic       ok;
        logic       fill_zero;
        logic       below_half;
        logic       half_minus1;
        logic       full;
        logic       gt_half;
        logic       out_free;
    } sts_t;

endpackage

/* src/pmc_ram.sv */
module pmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold the last read until the next one
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pmc_datapath.sv */
module pmc_datapath #(
    parameter int STACK_DEPTH = 16,
    parameter int CPU_COUNT   = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pmc_pkg::req_t req,
    input  pmc_pkg::cmd_t cmd,
    output pmc_pkg::sts_t sts,
    output pmc_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);

    import pmc_pkg::*;

    localparam int CPU_W     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int STK_N     = CPU_COUNT * SLOT_COUNT;
    localparam int STK_W     = $clog2(STK_N);
    localparam int IDX_W     = $clog2(STACK_DEPTH);
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int RAM_DEPTH = STK_N * (2 ** IDX_W);
    localparam logic [FILL_W-1:0] HALF = FILL_W'(STACK_DEPTH / 2);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(STACK_DEPTH);

    // captured item
    logic [1:0]        op_reg;
    logic              ok_reg;
    logic              unmanaged_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [CPU_W-1:0]  rcpu_reg;
    logic              rslot_reg;

    // refill bookkeeping
    logic              pend_reg;
    logic              pend_next;
    logic [CPU_W-1:0]  pcpu_reg;
    logic              pslot_reg;

    logic [FILL_W-1:0] fill_reg [STK_N];
    logic [FILL_W-1:0] fill_next;

    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    logic [CPU_W-1:0]  cpu_clamp;
    logic [CPU_W-1:0]  wcpu;
    logic              wslot;
    logic [STK_W-1:0]  stk;
    logic [FILL_W-1:0] fill;
    logic [PAGE_W-1:0] ram_rd_data;
    logic [3:0]        order_sel;

    assign cpu_clamp = (req.cpu < 8'(CPU_COUNT)) ? CPU_W'(req.cpu) : '0;

    // supply answers work on the stack that asked for the refill
    assign wcpu  = (op_reg == OP_SUPPLY) ? pcpu_reg : rcpu_reg;
    assign wslot = (op_reg == OP_SUPPLY) ? pslot_reg : rslot_reg;
    assign stk   = STK_W'({wcpu, wslot});
    assign fill  = fill_reg[stk];

    pmc_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (RAM_DEPTH)
    ) u_stacks (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr ({stk, IDX_W'(fill)}),
        .wr_data (page_reg),
        .rd_en   (cmd.pop),
        .rd_addr ({stk, IDX_W'(fill - 1'b1)}),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg        <= req.op;
            ok_reg        <= req.supply_ok;
            page_reg      <= req.page;
            rcpu_reg      <= cpu_clamp;
            rslot_reg     <= (req.size_class == BIG_ORDER);
            unmanaged_reg <= !((req.size_class == ORDER_SMALL) ||
                               (req.size_class == BIG_ORDER));
        end
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        fill_next = fill;
        if (cmd.pop)
        begin
            fill_next = fill - 1'b1;
        end
        else if (cmd.push)
        begin
            fill_next = fill + 1'b1;
        end
    end

    assign pend_next = cmd.set_pending ? 1'b1 : (cmd.clr_pending ? 1'b0 : pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STK_N; i++)
            begin
                fill_reg[i] <= '0;
            end
            pend_reg      <= 1'b0;
            pcpu_reg      <= '0;
            pslot_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg[stk] <= fill_next;
            pend_reg      <= pend_next;
            if (cmd.set_pending)
            begin
                pcpu_reg  <= rcpu_reg;
                pslot_reg <= rslot_reg;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign order_sel = wslot ? BIG_ORDER : ORDER_SMALL;

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.emit)
        begin
            rsp_next.kind = cmd.kind;
            rsp_next.last = cmd.last;
            case (cmd.psel)
                PS_IN:   rsp_next.page_out = page_reg;
                PS_RAM:  rsp_next.page_out = ram_rd_data;
                default: rsp_next.page_out = '0;
            endcase
            case (cmd.asel)
                AS_FILL:     rsp_next.amount = 5'(fill);
                AS_FILL_INC: rsp_next.amount = 5'(fill + 1'b1);
                AS_WANT:     rsp_next.amount = 5'(HALF - fill);
                default:     rsp_next.amount = '0;
            endcase
            rsp_next.order_out = ((cmd.kind == KIND_UNMANAGED) || (cmd.kind == KIND_STRAY))
                                 ? ORDER_SMALL : order_sel;
            rsp_next.cpu_out   = (cmd.kind == KIND_STRAY) ? 2'd0 : 2'(wcpu);
        end
    end

    assign rsp_valid_next = cmd.emit || (rsp_valid_reg && rsp_stall);

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign sts.op          = op_reg;
    assign sts.unmanaged   = unmanaged_reg;
    assign sts.pending     = pend_reg;
    assign sts.ok          = ok_reg;
    assign sts.fill_zero   = (fill == '0);
    assign sts.below_half  = (fill < HALF);
    assign sts.half_minus1 = ((fill + 1'b1) == HALF);
    assign sts.full        = (fill >= FULL);
    assign sts.gt_half     = (fill > HALF);
    assign sts.out_free    = !rsp_valid_reg || !rsp_stall;

endmodule

/* src/pmc_ctrl.sv */
module pmc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pmc_pkg::sts_t sts,
    output pmc_pkg::cmd_t cmd
);

    import pmc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_POP,
        S_EMIT,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.psel   = PS_ZERO;
        cmd.asel   = AS_ZERO;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // act only once the result register can take an item
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                    if (sts.op == OP_SUPPLY)
                    begin
                        if (!sts.pending)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_STRAY;
                            cmd.psel = PS_IN;
                            cmd.last = 1'b1;
                        end
                        else if (sts.ok && sts.below_half)
                        begin
                            cmd.push = 1'b1;
                            if (sts.half_minus1)
                            begin
                                cmd.clr_pending = 1'b1;
                                state_next      = S_POP;
                            end
                        end
                        else if (sts.ok)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.kind        = KIND_RETURN;
                            cmd.psel        = PS_IN;
                            cmd.asel        = AS_FILL;
                            cmd.clr_pending = 1'b1;
                            state_next      = S_POP;
                        end
                        else
                        begin
                            cmd.clr_pending = 1'b1;
                            if (sts.fill_zero)
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = KIND_FAIL;
                                cmd.last = 1'b1;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                    end
                    else if (sts.unmanaged)
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = KIND_UNMANAGED;
                        cmd.last = 1'b1;
                    end
                    else if (sts.op == OP_ALLOC)
                    begin
                        if (!sts.fill_zero)
                        begin
                            state_next = S_POP;
                        end
                        else if (sts.pending)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_FAIL;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.set_pending = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.kind        = KIND_REFILL;
                            cmd.asel        = AS_WANT;
                            cmd.last        = 1'b1;
                        end
                    end
                    else if (sts.op == OP_FREE)
                    begin
                        if (sts.full)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_FREED;
                            cmd.psel = PS_IN;
                            cmd.asel = AS_FILL_INC;
                            cmd.last = 1'b1;
                        end
                    end
                    else
                    begin
                        if (sts.fill_zero)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_EMPTY;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.psel = PS_RAM;
                    cmd.asel = AS_FILL;
                    if ((sts.op == OP_ALLOC) || (sts.op == OP_SUPPLY))
                    begin
                        cmd.kind   = KIND_GRANT;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (sts.op == OP_FREE)
                    begin
                        cmd.kind   = KIND_RETURN;
                        state_next = sts.gt_half ? S_POP : S_PUSH;
                    end
                    else
                    begin
                        cmd.kind   = KIND_RETURN;
                        cmd.last   = sts.fill_zero;
                        state_next = sts.fill_zero ? S_IDLE : S_POP;
                    end
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_FREED;
                    cmd.psel   = PS_IN;
                    cmd.asel   = AS_FILL_INC;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/per_cpu_page_magazine_cache_unit.sv */
// Per-cpu page magazine cache: one LIFO stack of page handles per cpu and
// per order (order 0 and order 9), backed by a refill handshake.
// Request channel (req_valid / req_stall / req): alloc, free, supply answer
// from the backing allocator, or drain. A cpu number at or above CPU_COUNT
// falls back to cpu 0. Response channel (rsp_valid / rsp_stall / rsp): one
// or more result items per request, the final one flagged by rsp.last;
// a supply that only tops up a refill gives no result at all.
// Sequence: a request is taken in the idle state and judged in the evaluate
// state, and each result is emitted into the result register. Each page
// popped from a stack passes a stack RAM read state and then a result
// state, so a grant from the stack goes idle, evaluate, pop, emit, and a
// drain repeats pop and emit for each page. The single-port-per-direction
// stack RAM and the one result register set this sequence.
// req_stall stays high until every result of the current request is in
// the result register. A stall on rsp holds the result register and the
// whole engine waits; nothing is dropped.
// Reset clears all fill counts and the pending refill; stack RAM contents
// are left as they are and are never read before they are written.
module per_cpu_page_magazine_cache_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int CPU_COUNT   = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pmc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pmc_pkg::rsp_t rsp
);

    import pmc_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequence each request: judge, pop pages, push, emit results
    pmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold fill counts, stack RAM, refill state and the result register
    pmc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .CPU_COUNT   (CPU_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule
